>>> rtl/mbw_pkg.sv
// Shared types, phase codes and box type lookup for the MP4 box header walker.
// No dependencies; imported by mbw_step and mp4_box_header_walker_core.
`default_nettype none

package mbw_pkg;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_FTYP   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  localparam int unsigned NUM_KINDS = 24;
  localparam logic [4:0] KIND_FTYP    = 5'd0;
  localparam logic [4:0] KIND_UNKNOWN = 5'd24;

  localparam logic [4:0]  PLAIN_HEADER     = 5'd8;
  localparam logic [4:0]  FTYP_EXTRA_BYTES = 5'd16;
  localparam logic [31:0] PLAIN_CONSUMED   = 32'd8;
  localparam logic [31:0] FTYP_CONSUMED    = 32'd24;

  localparam logic [31:0] KIND_FOURCC [NUM_KINDS] = '{
    "ftyp", "mdat", "moov", "pnot", "udta", "uuid", "moof", "free",
    "skip", "jP2 ", "wide", "load", "ctab", "imap", "matt", "kmat",
    "clip", "crgn", "sync", "chap", "tmcd", "scpt", "ssrc", "PICT"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } mbw_in_t;

  typedef struct packed {
    logic [4:0]  box_kind;
    logic [31:0] box_size;
    logic [31:0] box_fourcc;
    logic        short_box;
    logic        file_ended;
  } mbw_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [4:0]  header_count;
    logic [31:0] size_shift;
    logic [31:0] type_shift;
    logic [31:0] skip_remaining;
  } mbw_state_t;

  localparam mbw_state_t STATE_RESET = '{
    phase: PH_HEADER, header_count: 5'd0, size_shift: 32'd0,
    type_shift: 32'd0, skip_remaining: 32'd0
  };

  // Type codes are distinct, so at most one compare hits.
  function automatic logic [4:0] mbw_kind_of(input logic [31:0] fourcc);
    logic [4:0] kind;
    kind = KIND_UNKNOWN;
    for (int i = 0; i < NUM_KINDS; i++) begin
      if (KIND_FOURCC[i] == fourcc) kind = 5'(i);
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mp4_box_header_walker_core.sv
// Top level of the MP4 box header walker: input register, walker state and
// result register around mbw_step. Depends on mbw_pkg and mbw_step.
`default_nettype none

// Usage:
//   in_valid/in_ready/in_item carry one file byte per transaction, with
//   first_byte restarting the walk and last_byte closing the file.
//   out_valid/out_ready/out_item carry one box record per transaction,
//   produced when a box's eighth header byte is taken, or early with
//   file_ended set when the file stops inside a header.
//   Bytes of ftyp contents and of skipped payload produce no record.
// Path: an accepted byte waits in the input register, and its record is
//   written to the result register once that register can take it.
// Throughput: one byte per cycle unless a held record stalls; the walker
//   state updates as a byte moves from the input to the result register.
// Reset: synchronous rst empties both registers and returns the walker to
//   the start of a header.
// Stall: while out_ready is low and a record is held, the input register
//   keeps its byte; once it is full too, in_ready drops. Nothing is lost.
module mp4_box_header_walker_core
  import mbw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire mbw_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output mbw_out_t      out_item
);

  logic       s1_valid;
  mbw_in_t    s1_item;
  logic       s1_adv;
  mbw_state_t state;
  mbw_state_t state_next;
  mbw_out_t   rec;
  logic       rec_valid;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  mbw_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .rec        (rec),
    .rec_valid  (rec_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
        s1_item  <= in_item;
      end
      if (s1_adv) begin
        out_valid <= s1_valid && rec_valid;
        if (s1_valid) begin
          out_item <= rec;
          state    <= state_next;
        end
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SKIP |-> state.skip_remaining != 32'd0)
    else $error("skip phase with nothing left to skip");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_HEADER |-> state.header_count < PLAIN_HEADER) and
    (state.phase == PH_FTYP |-> state.header_count < FTYP_EXTRA_BYTES))
    else $error("header count out of range for phase");

  a_record_lands: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && rec_valid |=> out_valid)
    else $error("record lost between stages");

endmodule

`default_nettype wire

>>> rtl/mbw_step.sv
// Next-state and record logic for one byte of the box header walker.
// Depends on mbw_pkg.
`default_nettype none

module mbw_step
  import mbw_pkg::*;
(
  input  mbw_state_t state,
  input  mbw_in_t    item,
  output mbw_state_t state_next,
  output mbw_out_t   rec,
  output logic       rec_valid
);

  mbw_state_t  cur;
  logic [4:0]  hc_inc;
  logic [31:0] size_new;
  logic [31:0] type_new;
  logic [31:0] rec_size;
  logic [31:0] rec_type;
  logic [4:0]  rec_kind;
  logic [31:0] consumed;
  logic        rec_short;
  logic [31:0] rec_skip;
  logic [1:0]  pad_bytes;
  logic        emit;

  always_comb begin
    cur       = item.first_byte ? STATE_RESET : state;
    hc_inc    = cur.header_count + 5'd1;
    size_new  = cur.size_shift;
    type_new  = cur.type_shift;
    if (cur.header_count < 5'd4) size_new = {cur.size_shift[23:0], item.data_byte};
    else                         type_new = {cur.type_shift[23:0], item.data_byte};

    // Truncated header: left-align the bytes received, zero below them.
    if (hc_inc >= PLAIN_HEADER) begin
      pad_bytes = 2'd0;
      rec_size  = size_new;
      rec_type  = type_new;
    end else if (hc_inc <= 5'd4) begin
      pad_bytes = 2'd0 - hc_inc[1:0];
      rec_size  = size_new << {pad_bytes, 3'b000};
      rec_type  = 32'd0;
    end else begin
      pad_bytes = 2'd0 - hc_inc[1:0];
      rec_size  = size_new;
      rec_type  = type_new << {pad_bytes, 3'b000};
    end

    rec_kind  = mbw_kind_of(rec_type);
    consumed  = (rec_kind == KIND_FTYP) ? FTYP_CONSUMED : PLAIN_CONSUMED;
    rec_short = rec_size < consumed;
    rec_skip  = rec_short ? 32'd0 : rec_size - consumed;

    rec.box_kind   = rec_kind;
    rec.box_size   = rec_size;
    rec.box_fourcc = rec_type;
    rec.short_box  = rec_short;
    rec.file_ended = item.last_byte;

    emit       = 1'b0;
    state_next = cur;
    case (cur.phase)
      PH_FTYP: begin
        state_next.header_count = hc_inc;
        if (hc_inc >= FTYP_EXTRA_BYTES) begin
          state_next.header_count = 5'd0;
          state_next.phase = (cur.skip_remaining != 32'd0) ? PH_SKIP : PH_HEADER;
        end
      end
      PH_SKIP: begin
        state_next.skip_remaining = cur.skip_remaining - 32'd1;
        if (cur.skip_remaining == 32'd1) state_next.phase = PH_HEADER;
      end
      default: begin
        state_next.size_shift   = size_new;
        state_next.type_shift   = type_new;
        state_next.header_count = hc_inc;
        if (hc_inc >= PLAIN_HEADER || item.last_byte) begin
          emit = 1'b1;
          state_next.size_shift     = 32'd0;
          state_next.type_shift     = 32'd0;
          state_next.header_count   = 5'd0;
          state_next.skip_remaining = rec_skip;
          if (rec_kind == KIND_FTYP)      state_next.phase = PH_FTYP;
          else if (rec_skip != 32'd0)     state_next.phase = PH_SKIP;
          else                            state_next.phase = PH_HEADER;
        end
      end
    endcase

    // Drop all context after the final byte of a file.
    if (item.last_byte) state_next = STATE_RESET;
    rec_valid = emit;
  end

endmodule

`default_nettype wire
